@@ design/podt_pkg.sv @@
// shared types and constants for the presence off-delay table
package podt_pkg;

    localparam int AREA_MAX      = 8;
    localparam int NUM_AREAS_DEF = 8;
    localparam int COUNT_W       = 4;
    localparam int ID_W          = 8;
    localparam int DELAY_W       = 8;
    localparam int TIME_W        = 32;
    localparam int GEN_W         = 32;
    localparam int BUMP_W        = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_VALID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_IDS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAYS     = 3'd4;

    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_TICK  = 2'd1,
        OP_ACK   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // per-area settings handed to one cell
    typedef struct packed {
        logic               in_use;
        logic               enabled;
        logic               id_valid;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
    } area_cfg_t;

    // transaction as it travels down the row of cells
    typedef struct packed {
        op_t                 op;
        logic [ID_W-1:0]     area_id;
        logic                level;
        logic [TIME_W-1:0]   now;
        logic [GEN_W-1:0]    acked;
        logic                hit;
        logic [BUMP_W-1:0]   bumps;
        logic [AREA_MAX-1:0] active_mask;
        logic [AREA_MAX-1:0] known_mask;
        logic [TIME_W-1:0]   due_min;
    } token_t;

endpackage

@@ design/podt_cell.sv @@
// one area of the off-delay table: holds its state and updates the passing transaction
module podt_cell
    import podt_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic      clk,
    input  logic      rst_n,
    input  area_cfg_t cfg,
    input  logic      vld_in,
    input  token_t    tok_in,
    output logic      vld_out,
    output token_t    tok_out
);

    logic              seen_reg, seen_next;
    logic              level_reg, level_next;
    logic              active_reg, active_next;
    logic [TIME_W-1:0] due_reg, due_next;
    logic              vld_out_reg;
    token_t            tok_out_reg, tok_out_next;

    logic              changed;
    logic              bump;
    logic [TIME_W:0]   due_sum;
    logic [TIME_W-1:0] due_sat;

    always_comb
    begin
        seen_next    = seen_reg;
        level_next   = level_reg;
        active_next  = active_reg;
        due_next     = due_reg;
        tok_out_next = tok_in;
        changed      = 1'b0;
        bump         = 1'b0;
        // now + 2 * delay, saturating
        due_sum = {1'b0, tok_in.now} + (TIME_W+1)'({cfg.delay, 1'b0});
        due_sat = due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];

        if (vld_in)
        begin
            case (tok_in.op)
                OP_EVENT:
                begin
                    // lowest matching area takes the event
                    if (cfg.in_use && cfg.id_valid && cfg.id == tok_in.area_id && !tok_in.hit)
                    begin
                        tok_out_next.hit = 1'b1;
                        seen_next  = 1'b1;
                        level_next = tok_in.level;
                        if (tok_in.level)
                        begin
                            due_next = '0;
                            if (!active_reg)
                            begin
                                active_next = 1'b1;
                                changed     = 1'b1;
                            end
                        end
                        else if (active_reg && cfg.delay == '0)
                        begin
                            active_next = 1'b0;
                            due_next    = '0;
                            changed     = 1'b1;
                        end
                        else if (active_reg)
                        begin
                            due_next = due_sat;
                        end
                        else
                        begin
                            due_next = '0;
                        end
                        if (!seen_reg)
                        begin
                            changed = 1'b1;
                        end
                        bump = changed && cfg.enabled;
                    end
                end
                OP_TICK:
                begin
                    if (cfg.in_use && active_reg && !level_reg && due_reg != '0
                        && tok_in.now >= due_reg)
                    begin
                        active_next = 1'b0;
                        due_next    = '0;
                        bump        = cfg.enabled;
                    end
                end
                OP_ACK:
                begin
                end
                OP_CLEAR:
                begin
                    seen_next   = 1'b0;
                    level_next  = 1'b0;
                    active_next = 1'b0;
                    due_next    = '0;
                end
                default:
                begin
                end
            endcase
        end

        tok_out_next.bumps = tok_in.bumps + BUMP_W'(bump);
        if (cfg.in_use)
        begin
            tok_out_next.active_mask[CELL_IDX] = active_next;
            tok_out_next.known_mask[CELL_IDX]  = seen_next;
            if (due_next != '0 && (tok_in.due_min == '0 || due_next < tok_in.due_min))
            begin
                tok_out_next.due_min = due_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            level_reg   <= 1'b0;
            active_reg  <= 1'b0;
            due_reg     <= '0;
            vld_out_reg <= 1'b0;
        end
        else
        begin
            seen_reg    <= seen_next;
            level_reg   <= level_next;
            active_reg  <= active_next;
            due_reg     <= due_next;
            vld_out_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_out_reg <= tok_out_next;
    end

    assign vld_out = vld_out_reg;
    assign tok_out = tok_out_reg;

endmodule

@@ design/presence_off_delay_table_unit.sv @@
// top level of the presence off-delay table
//
// Input channel (in_valid / in_stall) carries one operation per transaction:
// a detector event, a time tick, a publish acknowledge or a reset of all areas.
// Output channel (out_valid / out_stall) returns one result per input
// transaction, in order, with the masks, pending flags, next publish time,
// generation and payload length taken after the operation.
// Each transaction walks a row of NUM_AREAS cells, one cell per cycle, and
// each cell updates its own area as the transaction passes. One transaction
// is in the row at a time, so the block takes no new transaction until the
// result of the last one is in the output register. in_stall stays high
// from acceptance until the result is in the output register; a stalled
// result holds there and keeps the next one waiting in the final stage.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
// the user must make them only while the block is idle, which the block
// itself does not enforce.
// Reset clears all area state, the pending flag, the generation counter and
// every configuration register.
module presence_off_delay_table_unit
    import podt_pkg::*;
#(
    parameter int NUM_AREAS = NUM_AREAS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            op,
    input  logic [ID_W-1:0]       event_area_id,
    input  logic                  event_level,
    input  logic [TIME_W-1:0]     now,
    input  logic [GEN_W-1:0]      acked_generation,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [AREA_MAX-1:0]   active_mask,
    output logic [AREA_MAX-1:0]   known_mask,
    output logic                  pending,
    output logic                  publish_due,
    output logic [TIME_W-1:0]     next_publish_time,
    output logic [GEN_W-1:0]      generation,
    output logic [COUNT_W-1:0]    payload_length
);

    localparam logic [COUNT_W-1:0] AREAS_W = COUNT_W'(NUM_AREAS);

    // configuration
    logic                      enabled_reg;
    logic [COUNT_W-1:0]        area_count_reg;
    logic [AREA_MAX-1:0]       id_valid_reg;
    logic [CFG_DATA_W-1:0]     area_ids_reg;
    logic [CFG_DATA_W-1:0]     delays_reg;
    logic [COUNT_W-1:0]        count_eff;

    // control
    logic                      busy_reg;
    logic                      launch_vld_reg;
    token_t                    launch_tok_reg;
    logic                      fin_vld_reg;
    token_t                    fin_tok_reg;
    logic                      pending_reg, pending_next;
    logic [GEN_W-1:0]          gen_reg, gen_next;
    logic                      accept;
    logic                      load;
    logic                      live;
    logic [TIME_W-1:0]         start_time;
    logic [TIME_W-1:0]         next_time;

    // output register
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [AREA_MAX-1:0]       active_mask_reg;
    logic [AREA_MAX-1:0]       known_mask_reg;
    logic                      pending_out_reg;
    logic                      publish_due_reg;
    logic [TIME_W-1:0]         next_time_reg;
    logic [GEN_W-1:0]          gen_out_reg;
    logic [COUNT_W-1:0]        length_reg;

    // row of cells
    logic                      chain_vld [NUM_AREAS+1];
    token_t                    chain_tok [NUM_AREAS+1];
    area_cfg_t                 cell_cfg  [NUM_AREAS];
    logic [NUM_AREAS+1:0]      flight_vec;

    assign count_eff = (area_count_reg > AREAS_W) ? AREAS_W : area_count_reg;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = busy_reg;
    assign load      = fin_vld_reg && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            area_count_reg <= '0;
            id_valid_reg   <= '0;
            area_ids_reg   <= '0;
            delays_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ENABLED:    enabled_reg    <= cfg_data[0];
                REG_AREA_COUNT: area_count_reg <= cfg_data[COUNT_W-1:0];
                REG_ID_VALID:   id_valid_reg   <= cfg_data[AREA_MAX-1:0];
                REG_AREA_IDS:   area_ids_reg   <= cfg_data;
                REG_DELAYS:     delays_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // launch stage feeds the first cell
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            launch_tok_reg.op          <= op_t'(op);
            launch_tok_reg.area_id     <= event_area_id;
            launch_tok_reg.level       <= event_level;
            launch_tok_reg.now         <= now;
            launch_tok_reg.acked       <= acked_generation;
            launch_tok_reg.hit         <= 1'b0;
            launch_tok_reg.bumps       <= '0;
            launch_tok_reg.active_mask <= '0;
            launch_tok_reg.known_mask  <= '0;
            launch_tok_reg.due_min     <= '0;
        end
    end

    assign chain_vld[0] = launch_vld_reg;
    assign chain_tok[0] = launch_tok_reg;

    for (genvar k = 0; k < NUM_AREAS; k++)
    begin : g_cell
        assign cell_cfg[k].in_use   = COUNT_W'(k) < count_eff;
        assign cell_cfg[k].enabled  = enabled_reg;
        assign cell_cfg[k].id_valid = id_valid_reg[k];
        assign cell_cfg[k].id       = area_ids_reg[k*ID_W +: ID_W];
        assign cell_cfg[k].delay    = delays_reg[k*DELAY_W +: DELAY_W];

        podt_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cell_cfg[k]),
            .vld_in  (chain_vld[k]),
            .tok_in  (chain_tok[k]),
            .vld_out (chain_vld[k+1]),
            .tok_out (chain_tok[k+1])
        );

        assign flight_vec[k] = chain_vld[k];
    end

    assign flight_vec[NUM_AREAS]   = chain_vld[NUM_AREAS];
    assign flight_vec[NUM_AREAS+1] = fin_vld_reg;

    always_ff @(posedge clk)
    begin
        if (chain_vld[NUM_AREAS])
        begin
            fin_tok_reg <= chain_tok[NUM_AREAS];
        end
    end

    // final stage: pending, generation and next publish time
    always_comb
    begin
        gen_next     = gen_reg + GEN_W'(fin_tok_reg.bumps);
        pending_next = pending_reg;
        case (fin_tok_reg.op)
            OP_EVENT,
            OP_TICK:
            begin
                pending_next = pending_reg || (fin_tok_reg.bumps != '0);
            end
            OP_ACK:
            begin
                if (fin_tok_reg.acked == gen_reg)
                begin
                    pending_next = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                pending_next = 1'b0;
                gen_next     = gen_reg + GEN_W'(1);
            end
            default:
            begin
            end
        endcase

        live       = enabled_reg && (count_eff != '0);
        start_time = pending_next ? fin_tok_reg.now : '0;
        next_time  = '0;
        if (live)
        begin
            next_time = start_time;
            if (fin_tok_reg.due_min != '0
                && (start_time == '0 || fin_tok_reg.due_min < start_time))
            begin
                next_time = fin_tok_reg.due_min;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            launch_vld_reg <= 1'b0;
            fin_vld_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            gen_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            launch_vld_reg <= accept;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end
            if (chain_vld[NUM_AREAS])
            begin
                fin_vld_reg <= 1'b1;
            end
            else if (load)
            begin
                fin_vld_reg <= 1'b0;
            end
            if (load)
            begin
                pending_reg   <= pending_next;
                gen_reg       <= gen_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg         <= fin_tok_reg.hit;
            active_mask_reg <= fin_tok_reg.active_mask;
            known_mask_reg  <= fin_tok_reg.known_mask;
            pending_out_reg <= pending_next;
            publish_due_reg <= live && pending_next;
            next_time_reg   <= next_time;
            gen_out_reg     <= gen_next;
            length_reg      <= count_eff;
        end
    end

    assign out_valid         = out_valid_reg;
    assign hit               = hit_reg;
    assign active_mask       = active_mask_reg;
    assign known_mask        = known_mask_reg;
    assign pending           = pending_out_reg;
    assign publish_due       = publish_due_reg;
    assign next_publish_time = next_time_reg;
    assign generation        = gen_out_reg;
    assign payload_length    = length_reg;

    // at most one transaction in the row and final stage
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(flight_vec))
        else $error("more than one transaction in flight");

    // an accepted transaction enters the first cell next cycle
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (launch_vld_reg && busy_reg))
        else $error("accepted transaction not launched");

    // anything in flight keeps the input stalled
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(flight_vec) != 0) |-> busy_reg)
        else $error("transaction in flight while input open");

    // publish due only with pending
    a_due_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && publish_due) |-> pending)
        else $error("publish due without pending");

    // masks cover only areas in use
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((active_mask | known_mask) >> payload_length) == '0))
        else $error("mask bit beyond area count");

endmodule

@@ verif/presence_off_delay_table_unit_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the presence off-delay table: directed cases, then random traffic
module presence_off_delay_table_unit_test;
    import podt_pkg::*;

    localparam int LATENCY     = NUM_AREAS_DEF + 3;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        hit;
        logic [7:0]  active_mask;
        logic [7:0]  known_mask;
        logic        pending;
        logic        publish_due;
        logic [31:0] next_publish_time;
        logic [31:0] generation;
        logic [3:0]  payload_length;
    } table_snapshot_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            op = OP_TICK;
    logic [ID_W-1:0]       event_area_id = '0;
    logic                  event_level = 1'b0;
    logic [TIME_W-1:0]     now = '0;
    logic [GEN_W-1:0]      acked_generation = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  hit;
    logic [AREA_MAX-1:0]   active_mask;
    logic [AREA_MAX-1:0]   known_mask;
    logic                  pending;
    logic                  publish_due;
    logic [TIME_W-1:0]     next_publish_time;
    logic [GEN_W-1:0]      generation;
    logic [COUNT_W-1:0]    payload_length;

    // predicted area table and its settings
    logic [7:0]  area_seen = '0;
    logic [7:0]  area_level = '0;
    logic [7:0]  area_active = '0;
    logic [31:0] area_due [8];
    logic        pend_flag = 1'b0;
    logic [31:0] gen_count = '0;
    logic        en_cfg = 1'b0;
    logic [3:0]  count_cfg = '0;
    logic [7:0]  id_valid_cfg = '0;
    logic [63:0] ids_cfg = '0;
    logic [63:0] delays_cfg = '0;

    table_snapshot_t table_snapshots[$];
    logic [31:0]     sim_seconds = 32'd50;
    bit              calm = 1'b0;
    int              fail_count = 0;
    int              cycle_count = 0;

    presence_off_delay_table_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .event_area_id     (event_area_id),
        .event_level       (event_level),
        .now               (now),
        .acked_generation  (acked_generation),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .hit               (hit),
        .active_mask       (active_mask),
        .known_mask        (known_mask),
        .pending           (pending),
        .publish_due       (publish_due),
        .next_publish_time (next_publish_time),
        .generation        (generation),
        .payload_length    (payload_length)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            area_due[i] = '0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("presence_off_delay_table_unit verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 23);
    end

    // applies one transaction to the predicted table and queues the result it should give
    function automatic void advance_table(op_t code, logic [7:0] ev_id, logic lvl,
                                          logic [31:0] t_now, logic [31:0] t_acked);
        int              n;
        int              sel;
        logic            changed;
        logic            live;
        logic [7:0]      dly;
        logic [33:0]     sum;
        logic [31:0]     next_t;
        table_snapshot_t s;
        n = (count_cfg > AREA_MAX) ? AREA_MAX : int'(count_cfg);
        sel = -1;
        s = '0;
        case (code)
            OP_EVENT:
            begin
                for (int i = 0; i < n; i++)
                    if (sel < 0 && id_valid_cfg[i] && ids_cfg[i*8 +: 8] == ev_id)
                        sel = i;
                if (sel >= 0)
                begin
                    s.hit = 1'b1;
                    changed = !area_seen[sel];
                    dly = delays_cfg[sel*8 +: 8];
                    area_seen[sel] = 1'b1;
                    area_level[sel] = lvl;
                    if (lvl)
                    begin
                        area_due[sel] = '0;
                        if (!area_active[sel])
                        begin
                            area_active[sel] = 1'b1;
                            changed = 1'b1;
                        end
                    end
                    else if (area_active[sel] && dly == 8'd0)
                    begin
                        area_active[sel] = 1'b0;
                        area_due[sel] = '0;
                        changed = 1'b1;
                    end
                    else if (area_active[sel])
                    begin
                        // off-delay is twice the configured delay, saturating
                        sum = {2'b00, t_now} + {25'b0, dly, 1'b0};
                        area_due[sel] = (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
                    end
                    else
                        area_due[sel] = '0;
                    if (changed && en_cfg)
                    begin
                        pend_flag = 1'b1;
                        gen_count = gen_count + 1;
                    end
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < n; i++)
                    if (area_active[i] && !area_level[i] && area_due[i] != 0
                        && t_now >= area_due[i])
                    begin
                        area_active[i] = 1'b0;
                        area_due[i] = '0;
                        if (en_cfg)
                        begin
                            pend_flag = 1'b1;
                            gen_count = gen_count + 1;
                        end
                    end
            end
            OP_ACK:
            begin
                if (t_acked == gen_count)
                    pend_flag = 1'b0;
            end
            default:
            begin
                area_seen = '0;
                area_level = '0;
                area_active = '0;
                for (int i = 0; i < 8; i++)
                    area_due[i] = '0;
                pend_flag = 1'b0;
                gen_count = gen_count + 1;
            end
        endcase

        for (int i = 0; i < n; i++)
        begin
            s.active_mask[i] = area_active[i];
            s.known_mask[i] = area_seen[i];
        end
        live = en_cfg && n > 0;
        next_t = '0;
        if (live)
        begin
            next_t = pend_flag ? t_now : 32'd0;
            for (int i = 0; i < n; i++)
                if (area_due[i] != 0 && (next_t == 0 || area_due[i] < next_t))
                    next_t = area_due[i];
        end
        s.pending = pend_flag;
        s.publish_due = live && pend_flag;
        s.next_publish_time = next_t;
        s.generation = gen_count;
        s.payload_length = 4'(n);
        table_snapshots.push_back(s);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        table_snapshot_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (table_snapshots.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                fail_count++;
            end
            else
            begin
                want = table_snapshots.pop_front();
                compare_field("hit", 32'(want.hit), 32'(hit));
                compare_field("active_mask", 32'(want.active_mask), 32'(active_mask));
                compare_field("known_mask", 32'(want.known_mask), 32'(known_mask));
                compare_field("pending", 32'(want.pending), 32'(pending));
                compare_field("publish_due", 32'(want.publish_due), 32'(publish_due));
                compare_field("next_publish_time", want.next_publish_time, next_publish_time);
                compare_field("generation", want.generation, generation);
                compare_field("payload_length", 32'(want.payload_length),
                              32'(payload_length));
            end
        end
    end

    task automatic send_item(op_t code, logic [7:0] ev_id, logic lvl,
                             logic [31:0] t_now, logic [31:0] t_acked);
        if (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        event_area_id <= ev_id;
        event_level <= lvl;
        now <= t_now;
        acked_generation <= t_acked;
        do @(posedge clk); while (in_stall);
        advance_table(code, ev_id, lvl, t_now, t_acked);
    endtask

    // settings change only with nothing in flight
    task automatic drain_table;
        in_valid <= 1'b0;
        while (table_snapshots.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_ENABLED:    en_cfg = val[0];
            REG_AREA_COUNT: count_cfg = val[3:0];
            REG_ID_VALID:   id_valid_cfg = val[7:0];
            REG_AREA_IDS:   ids_cfg = val;
            REG_DELAYS:     delays_cfg = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(logic en, logic [3:0] cnt, logic [7:0] valid_bits,
                                logic [63:0] ids, logic [63:0] dly);
        drain_table;
        write_reg(REG_ENABLED, 64'(en));
        write_reg(REG_AREA_COUNT, 64'(cnt));
        write_reg(REG_ID_VALID, 64'(valid_bits));
        write_reg(REG_AREA_IDS, ids);
        write_reg(REG_DELAYS, dly);
        cfg_write <= 1'b0;
    endtask

    task automatic run_traffic(int items);
        int          n;
        int          pick;
        int          roll;
        op_t         code;
        logic [7:0]  ev_id;
        logic [31:0] t_now;
        logic [31:0] t_acked;
        n = (count_cfg > AREA_MAX) ? AREA_MAX : int'(count_cfg);
        for (int k = 0; k < items; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 50)
                code = OP_EVENT;
            else if (roll < 80)
                code = OP_TICK;
            else if (roll < 96)
                code = OP_ACK;
            else
                code = OP_CLEAR;
            // mostly ids of areas in use so events land
            if (n > 0 && $urandom_range(99) < 85)
            begin
                pick = $urandom_range(0, n - 1);
                ev_id = ids_cfg[pick*8 +: 8];
            end
            else
                ev_id = 8'($urandom);
            t_now = ($urandom_range(19) == 0) ? 32'($urandom) : sim_seconds;
            sim_seconds = sim_seconds + $urandom_range(0, 3);
            roll = $urandom_range(9);
            if (roll < 6)
                t_acked = gen_count;
            else if (roll < 8)
                t_acked = gen_count - 1;
            else
                t_acked = 32'($urandom);
            send_item(code, ev_id, 1'($urandom_range(0, 1)), t_now, t_acked);
        end
    endtask

    task automatic configure_phase(int p);
        logic [63:0] ids;
        logic [63:0] dly;
        logic [7:0]  b;
        logic [3:0]  cnt;
        logic [7:0]  valid_bits;
        logic        en;
        for (int i = 0; i < 8; i++)
        begin
            // small id pool forces duplicates
            ids[i*8 +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom);
            case ($urandom_range(3))
                0:       b = 8'd0;
                1:       b = 8'($urandom_range(1, 3));
                2:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            dly[i*8 +: 8] = b;
        end
        case (p)
            0, 1:    cnt = 4'd8;
            2:       cnt = 4'd0;
            3:       cnt = 4'hF;
            4:       cnt = 4'd1;
            default: cnt = 4'($urandom_range(1, 8));
        endcase
        if (p == 5)
            valid_bits = 8'h00;
        else
            valid_bits = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
        if (p == 0)
            en = 1'b1;
        else if (p == 1)
            en = 1'b0;
        else
            en = ($urandom_range(3) != 0);
        apply_config(en, cnt, valid_bits, ids, dly);
        if (p == 6)
            sim_seconds = 32'hFFFF_FE00;
    endtask

    task automatic test_reset_state;
        send_item(OP_EVENT, 8'h00, 1'b1, 32'd0, 32'd0);
        send_item(OP_TICK, 8'hFF, 1'b0, 32'hFFFF_FFFF, 32'd0);
        send_item(OP_ACK, 8'h00, 1'b0, 32'd5, 32'd0);
        send_item(OP_CLEAR, 8'h00, 1'b0, 32'd6, 32'd0);
    endtask

    task automatic test_event_cases;
        // areas 0..3 in use, areas 2 and 3 share an id, area 4 lies beyond the count
        apply_config(1'b1, 4'd4, 8'hFF,
                     {8'h33, 8'h33, 8'h33, 8'h33, 8'h10, 8'h10, 8'hFF, 8'h00},
                     {32'h0, 8'd1, 8'd3, 8'hFF, 8'h00});
        send_item(OP_EVENT, 8'h00, 1'b1, 32'd100, 32'd0);
        send_item(OP_EVENT, 8'h00, 1'b0, 32'd101, 32'd0);
        send_item(OP_EVENT, 8'hFF, 1'b0, 32'd102, 32'd0);
        send_item(OP_EVENT, 8'hFF, 1'b1, 32'd103, 32'd0);
        send_item(OP_EVENT, 8'hFF, 1'b0, 32'hFFFF_FF80, 32'd0);
        send_item(OP_EVENT, 8'h10, 1'b1, 32'd200, 32'd0);
        send_item(OP_EVENT, 8'h10, 1'b0, 32'd201, 32'd0);
        send_item(OP_TICK, 8'h00, 1'b0, 32'd206, 32'd0);
        send_item(OP_TICK, 8'h00, 1'b0, 32'd207, 32'd0);
        send_item(OP_EVENT, 8'h55, 1'b1, 32'd208, 32'd0);
        send_item(OP_EVENT, 8'h33, 1'b1, 32'd209, 32'd0);
        send_item(OP_ACK, 8'h00, 1'b0, 32'd210, 32'hFFFF_FFFF);
        send_item(OP_ACK, 8'h00, 1'b0, 32'd211, gen_count);
        send_item(OP_TICK, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'd0);
        send_item(OP_CLEAR, 8'h00, 1'b0, 32'd300, 32'd0);
    endtask

    task automatic test_disabled_publish;
        apply_config(1'b0, 4'd4, 8'hFF, ids_cfg, delays_cfg);
        send_item(OP_EVENT, 8'h10, 1'b1, 32'd400, 32'd0);
        send_item(OP_EVENT, 8'h10, 1'b0, 32'd401, 32'd0);
        send_item(OP_TICK, 8'h00, 1'b0, 32'd500, 32'd0);
        send_item(OP_CLEAR, 8'h00, 1'b0, 32'd600, 32'd0);
    endtask

    task automatic test_random_traffic;
        for (int p = 0; p < 8; p++)
        begin
            configure_phase(p);
            run_traffic(75);
        end
    endtask

    task automatic test_unstalled_stream;
        configure_phase(0);
        calm = 1'b1;
        run_traffic(60);
        drain_table;
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state;
        test_event_cases;
        test_disabled_publish;
        test_random_traffic;
        test_unstalled_stream;
        drain_table;
        if (fail_count == 0)
            $display("presence_off_delay_table_unit verification clean");
        else
            $display("presence_off_delay_table_unit verification failed");
        $finish;
    end

endmodule
